// File: hw/rtl/dmsp_pkg.sv
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared constants of the DNS message stream parser: section and field codes
// and the bound on the length of a name.
// ----------------------------------------------------------------------------
package dmsp_pkg;

  localparam int unsigned NameMax  = 256;
  localparam int unsigned NameLenW = 9;

  localparam logic [2:0] SEC_HEADER     = 3'd0;
  localparam logic [2:0] SEC_QUESTION   = 3'd1;
  localparam logic [2:0] SEC_ANSWER     = 3'd2;
  localparam logic [2:0] SEC_AUTHORITY  = 3'd3;
  localparam logic [2:0] SEC_ADDITIONAL = 3'd4;
  localparam logic [2:0] SEC_TRAILING   = 3'd5;

  localparam logic [3:0] KIND_ID        = 4'd0;
  localparam logic [3:0] KIND_FLAGS     = 4'd1;
  localparam logic [3:0] KIND_QDCOUNT   = 4'd2;
  localparam logic [3:0] KIND_ANCOUNT   = 4'd3;
  localparam logic [3:0] KIND_NSCOUNT   = 4'd4;
  localparam logic [3:0] KIND_ARCOUNT   = 4'd5;
  localparam logic [3:0] KIND_LABEL_LEN = 4'd6;
  localparam logic [3:0] KIND_LABEL_CHR = 4'd7;
  localparam logic [3:0] KIND_POINTER   = 4'd8;
  localparam logic [3:0] KIND_NAME_END  = 4'd9;
  localparam logic [3:0] KIND_TYPE      = 4'd10;
  localparam logic [3:0] KIND_CLASS     = 4'd11;
  localparam logic [3:0] KIND_TTL       = 4'd12;
  localparam logic [3:0] KIND_RDLENGTH  = 4'd13;
  localparam logic [3:0] KIND_RDATA     = 4'd14;
  localparam logic [3:0] KIND_EXTRA     = 4'd15;

endpackage

// File: hw/rtl/dns_message_stream_parser.sv
// ----------------------------------------------------------------------------
// dns_message_stream_parser
// The token for an accepted byte is written to the output register at the edge that accepts the byte.
// Throughput: one message byte per cycle; the only stall is a full output register.
// The whole parse step is one pass of logic from the phase registers to the output register.
// Reset (rst, synchronous) returns the parse to the header id and empties the output.
// ----------------------------------------------------------------------------
// Parses a DNS message one byte per word and emits one token per byte that
// names its section and field, with big-endian field values and the decoded
// flags word. Compression pointers end a name and are not followed.
// ----------------------------------------------------------------------------
module dns_message_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  msg_byte,
  input  logic        msg_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  section,
  output logic [3:0]  field_kind,
  output logic [31:0] value,
  output logic        field_done,
  output logic        qr_flag,
  output logic [3:0]  op_code,
  output logic        aa_flag,
  output logic        tc_flag,
  output logic        rd_flag,
  output logic        ra_flag,
  output logic [3:0]  resp_code,
  output logic        name_overflow
);
  import dmsp_pkg::*;

  typedef enum logic [3:0] {
    PH_ID, PH_FLAGS, PH_QD, PH_AN, PH_NS, PH_AR, PH_NLEN, PH_NCHAR, PH_NPTR,
    PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN, PH_RDATA, PH_TRAIL
  } phase_t;

  localparam logic [15:0] OpcodeMask = 16'h7800;

  phase_t      parse_phase, parse_phase_next, ph;
  logic [1:0]  byte_in_field, byte_in_field_next, bif;
  logic [31:0] field_accum, field_accum_next, acc;
  logic [15:0] answers_left, answers_left_next, an_b;
  logic [15:0] authority_left, authority_left_next, ns_b;
  logic [15:0] additional_left, additional_left_next, ar_b;
  logic [15:0] rdata_left, rdata_left_next, rd_b;
  logic [7:0]  label_left, label_left_next, ll_b;
  logic [NameLenW-1:0] name_length, name_length_next, nl_b;
  logic [2:0]  cur_section, cur_section_next, cs_b;
  logic [15:0] flags_word, flags_word_next, fw_b;

  logic [2:0]  sec_res;
  logic [3:0]  kind_res;
  logic [31:0] val_res;
  logic        done_res;
  logic        in_name;
  logic        take;
  logic        take_done;
  logic        go_next;
  logic [31:0] acc_shift;
  logic [NameLenW:0] len_sum;
  logic        accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (msg_start) begin
      ph = PH_ID;   bif = '0;  acc = '0;  an_b = '0;  ns_b = '0;  ar_b = '0;
      rd_b = '0;    ll_b = '0; nl_b = '0; cs_b = SEC_HEADER;       fw_b = '0;
    end else begin
      ph = parse_phase;       bif = byte_in_field;    acc = field_accum;
      an_b = answers_left;    ns_b = authority_left;  ar_b = additional_left;
      rd_b = rdata_left;      ll_b = label_left;      nl_b = name_length;
      cs_b = cur_section;     fw_b = flags_word;
    end

    parse_phase_next     = ph;
    byte_in_field_next   = bif;
    field_accum_next     = acc;
    answers_left_next    = an_b;
    authority_left_next  = ns_b;
    additional_left_next = ar_b;
    rdata_left_next      = rd_b;
    label_left_next      = ll_b;
    name_length_next     = nl_b;
    cur_section_next     = cs_b;
    flags_word_next      = fw_b;

    sec_res   = cs_b;
    kind_res  = KIND_EXTRA;
    val_res   = '0;
    done_res  = 1'b0;
    in_name   = 1'b0;
    take      = 1'b0;
    go_next   = 1'b0;
    len_sum   = '0;
    acc_shift = {acc[23:0], msg_byte};
    take_done = (ph == PH_TTL) ? (bif == 2'd3) : (bif != 2'd0);

    case (ph)
      PH_ID, PH_FLAGS, PH_QD, PH_AN, PH_NS, PH_AR: begin
        kind_res = 4'(ph);
        take     = 1'b1;
        if (take_done) begin
          case (ph)
            PH_FLAGS: flags_word_next      = acc_shift[15:0];
            PH_AN:    answers_left_next    = acc_shift[15:0];
            PH_NS:    authority_left_next  = acc_shift[15:0];
            PH_AR:    additional_left_next = acc_shift[15:0];
            default:  flags_word_next      = fw_b;
          endcase
          if (ph == PH_AR) begin
            cur_section_next = SEC_QUESTION;
            name_length_next = '0;
            label_left_next  = '0;
            parse_phase_next = PH_NLEN;
          end else begin
            parse_phase_next = phase_t'(4'(ph) + 4'd1);
          end
        end
      end
      PH_NLEN: begin
        in_name = 1'b1;
        if (msg_byte[7:6] == 2'b11) begin
          kind_res           = KIND_POINTER;
          field_accum_next   = {26'd0, msg_byte[5:0]};
          byte_in_field_next = 2'd1;
          val_res            = {26'd0, msg_byte[5:0]};
          parse_phase_next   = PH_NPTR;
        end else if (msg_byte == 8'd0) begin
          kind_res         = KIND_NAME_END;
          done_res         = 1'b1;
          parse_phase_next = PH_TYPE;
        end else begin
          kind_res         = KIND_LABEL_LEN;
          val_res          = {24'd0, msg_byte};
          done_res         = 1'b1;
          label_left_next  = msg_byte;
          len_sum          = {1'b0, nl_b} + {{(NameLenW - 7){1'b0}}, msg_byte}
                             + {{NameLenW{1'b0}}, 1'b1};
          name_length_next = len_sum[NameLenW] ? {NameLenW{1'b1}}
                                               : len_sum[NameLenW-1:0];
          parse_phase_next = PH_NCHAR;
        end
      end
      PH_NCHAR: begin
        in_name         = 1'b1;
        kind_res        = KIND_LABEL_CHR;
        val_res         = {24'd0, msg_byte};
        done_res        = 1'b1;
        label_left_next = ll_b - 8'd1;
        if (ll_b == 8'd1) begin
          parse_phase_next = PH_NLEN;
        end
      end
      PH_NPTR: begin
        in_name            = 1'b1;
        kind_res           = KIND_POINTER;
        val_res            = {18'd0, acc[5:0], msg_byte};
        done_res           = 1'b1;
        field_accum_next   = '0;
        byte_in_field_next = 2'd0;
        parse_phase_next   = PH_TYPE;
      end
      PH_TYPE: begin
        kind_res = KIND_TYPE;
        take     = 1'b1;
        if (take_done) begin
          parse_phase_next = PH_CLASS;
        end
      end
      PH_CLASS: begin
        kind_res = KIND_CLASS;
        take     = 1'b1;
        if (take_done) begin
          if (cs_b == SEC_QUESTION) begin
            go_next = 1'b1;
          end else begin
            parse_phase_next = PH_TTL;
          end
        end
      end
      PH_TTL: begin
        kind_res = KIND_TTL;
        take     = 1'b1;
        if (take_done) begin
          parse_phase_next = PH_RDLEN;
        end
      end
      PH_RDLEN: begin
        kind_res = KIND_RDLENGTH;
        take     = 1'b1;
        if (take_done) begin
          rdata_left_next = acc_shift[15:0];
          if (acc_shift[15:0] == 16'd0) begin
            go_next = 1'b1;
          end else begin
            parse_phase_next = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        kind_res        = KIND_RDATA;
        val_res         = {24'd0, msg_byte};
        done_res        = 1'b1;
        rdata_left_next = rd_b - 16'd1;
        if (rd_b == 16'd1) begin
          go_next = 1'b1;
        end
      end
      default: begin
        sec_res          = SEC_TRAILING;
        cur_section_next = SEC_TRAILING;
        parse_phase_next = PH_TRAIL;
        kind_res         = KIND_EXTRA;
        val_res          = {24'd0, msg_byte};
        done_res         = 1'b1;
      end
    endcase

    if (take) begin
      val_res  = acc_shift;
      done_res = take_done;
      if (take_done) begin
        byte_in_field_next = 2'd0;
        field_accum_next   = '0;
      end else begin
        byte_in_field_next = bif + 2'd1;
        field_accum_next   = acc_shift;
      end
    end

    if (go_next) begin
      if (an_b != 16'd0) begin
        answers_left_next = an_b - 16'd1;
        cur_section_next  = SEC_ANSWER;
        parse_phase_next  = PH_NLEN;
      end else if (ns_b != 16'd0) begin
        authority_left_next = ns_b - 16'd1;
        cur_section_next    = SEC_AUTHORITY;
        parse_phase_next    = PH_NLEN;
      end else if (ar_b != 16'd0) begin
        additional_left_next = ar_b - 16'd1;
        cur_section_next     = SEC_ADDITIONAL;
        parse_phase_next     = PH_NLEN;
      end else begin
        cur_section_next = SEC_TRAILING;
        parse_phase_next = PH_TRAIL;
      end
      if (an_b != 16'd0 || ns_b != 16'd0 || ar_b != 16'd0) begin
        name_length_next   = '0;
        label_left_next    = '0;
        byte_in_field_next = 2'd0;
        field_accum_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_ID;
      byte_in_field   <= '0;
      field_accum     <= '0;
      answers_left    <= '0;
      authority_left  <= '0;
      additional_left <= '0;
      rdata_left      <= '0;
      label_left      <= '0;
      name_length     <= '0;
      cur_section     <= SEC_HEADER;
      flags_word      <= '0;
      out_valid       <= 1'b0;
    end else begin
      out_valid <= accept | (out_valid & out_stall);
      if (accept) begin
        parse_phase     <= parse_phase_next;
        byte_in_field   <= byte_in_field_next;
        field_accum     <= field_accum_next;
        answers_left    <= answers_left_next;
        authority_left  <= authority_left_next;
        additional_left <= additional_left_next;
        rdata_left      <= rdata_left_next;
        label_left      <= label_left_next;
        name_length     <= name_length_next;
        cur_section     <= cur_section_next;
        flags_word      <= flags_word_next;
      end
    end
    if (accept) begin
      section       <= sec_res;
      field_kind    <= kind_res;
      value         <= val_res;
      field_done    <= done_res;
      qr_flag       <= flags_word_next[15];
      op_code       <= 4'((flags_word_next & OpcodeMask) >> 11);
      aa_flag       <= flags_word_next[10];
      tc_flag       <= flags_word_next[9];
      rd_flag       <= flags_word_next[8];
      ra_flag       <= flags_word_next[7];
      resp_code     <= flags_word_next[3:0];
      name_overflow <= in_name && (name_length_next > NameLenW'(NameMax));
    end
  end

endmodule

// File: hw/rtl/dmsp_checker.sv
// ----------------------------------------------------------------------------
// dmsp_checker
// Port-level checks of the DNS message stream parser, bound to its top level.
// ----------------------------------------------------------------------------
module dmsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  msg_byte,
  input logic        msg_start,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  section,
  input logic [3:0]  field_kind,
  input logic [31:0] value,
  input logic        field_done,
  input logic        qr_flag,
  input logic [3:0]  op_code,
  input logic        aa_flag,
  input logic        tc_flag,
  input logic        rd_flag,
  input logic        ra_flag,
  input logic [3:0]  resp_code,
  input logic        name_overflow
);
  import dmsp_pkg::*;

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input not stalled while the output word waits");

  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(field_kind))
    else $error("stalled output word changed");

  a_trailing: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_kind == KIND_EXTRA |-> section == SEC_TRAILING && field_done)
    else $error("trailing byte token outside the trailing section");

  a_pointer_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_kind == KIND_POINTER |-> value[31:14] == 18'd0)
    else $error("pointer offset wider than 14 bits");

  a_overflow_in_name: assert property (@(posedge clk) disable iff (rst)
    out_valid && name_overflow |->
      field_kind == KIND_LABEL_LEN || field_kind == KIND_LABEL_CHR ||
      field_kind == KIND_POINTER || field_kind == KIND_NAME_END)
    else $error("name overflow flagged on a token outside a name");

endmodule

bind dns_message_stream_parser dmsp_checker u_dmsp_checker (.*);

// File: test/dns_message_stream_parser_tb.sv
// ----------------------------------------------------------------------------
// dns_message_stream_parser_tb
// Drives DNS messages into the parser one byte per word with random gaps and
// output stalls. A model of the parse runs alongside and predicts the token
// for every accepted byte. Each token is checked field by field, in order.
// Directed messages cover reset, restart, flag extremes, pointers, empty
// rdata, trailing bytes and long names. Random messages follow, some of them
// cut short, with noise in between.
// ----------------------------------------------------------------------------
module dns_message_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmsp_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;

  typedef enum logic [4:0] {
    PH_ID, PH_FLAGS, PH_QD, PH_AN, PH_NS, PH_AR, PH_NLEN, PH_NCHAR, PH_NPTR,
    PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN, PH_RDATA, PH_TRAIL
  } parse_phase_t;

  typedef struct packed {
    logic [2:0]  sec;
    logic [3:0]  kind;
    logic [31:0] value;
    logic        done;
    logic        qr;
    logic [3:0]  op;
    logic        aa;
    logic        tc;
    logic        rd;
    logic        ra;
    logic [3:0]  rcode;
    logic        ovf;
  } dns_token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  msg_byte = 8'h00;
  logic        msg_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  section;
  logic [3:0]  field_kind;
  logic [31:0] value;
  logic        field_done;
  logic        qr_flag;
  logic [3:0]  op_code;
  logic        aa_flag;
  logic        tc_flag;
  logic        rd_flag;
  logic        ra_flag;
  logic [3:0]  resp_code;
  logic        name_overflow;

  parse_phase_t phase;
  logic [1:0]   byte_cnt;
  logic [31:0]  accum;
  logic [15:0]  an_left;
  logic [15:0]  ns_left;
  logic [15:0]  ar_left;
  logic [15:0]  rd_left;
  logic [7:0]   lbl_left;
  logic [8:0]   name_len;
  logic [2:0]   cur_sec;
  logic [15:0]  flags;

  dns_token_t  expected_tokens[$];
  logic [7:0]  wire_bytes[$];
  int unsigned bytes_sent = 0;
  int unsigned msgs_sent = 0;
  int unsigned tokens_checked = 0;
  int unsigned overflow_seen = 0;
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_hold = 0;
  bit          steady = 1'b0;

  dns_message_stream_parser i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_parse();
    phase    = PH_ID;
    byte_cnt = '0;
    accum    = '0;
    an_left  = '0;
    ns_left  = '0;
    ar_left  = '0;
    rd_left  = '0;
    lbl_left = '0;
    name_len = '0;
    cur_sec  = SEC_HEADER;
    flags    = '0;
  endfunction

  function automatic logic shift_field(input int unsigned n, input logic [7:0] b,
                                       output logic [31:0] v);
    accum = {accum[23:0], b};
    v = accum;
    if (int'(byte_cnt) + 1 >= n) begin
      byte_cnt = '0;
      accum = '0;
      return 1'b1;
    end
    byte_cnt = byte_cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic void start_name();
    name_len = '0;
    lbl_left = '0;
    byte_cnt = '0;
    accum    = '0;
    phase    = PH_NLEN;
  endfunction

  function automatic void next_record();
    if (an_left != 0) begin
      an_left = an_left - 16'd1;
      cur_sec = SEC_ANSWER;
      start_name();
    end else if (ns_left != 0) begin
      ns_left = ns_left - 16'd1;
      cur_sec = SEC_AUTHORITY;
      start_name();
    end else if (ar_left != 0) begin
      ar_left = ar_left - 16'd1;
      cur_sec = SEC_ADDITIONAL;
      start_name();
    end else begin
      cur_sec = SEC_TRAILING;
      phase = PH_TRAIL;
    end
  endfunction

  function automatic dns_token_t parse_byte(input logic [7:0] b, input logic st);
    dns_token_t tok;
    logic       in_name;
    logic [9:0] grown;
    tok = '0;
    tok.kind = KIND_EXTRA;
    in_name = 1'b0;
    if (st) clear_parse();
    tok.sec = cur_sec;
    case (phase)
      PH_ID: begin
        tok.kind = KIND_ID;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) phase = PH_FLAGS;
      end
      PH_FLAGS: begin
        tok.kind = KIND_FLAGS;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) begin
          flags = tok.value[15:0];
          phase = PH_QD;
        end
      end
      PH_QD: begin
        tok.kind = KIND_QDCOUNT;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) phase = PH_AN;
      end
      PH_AN: begin
        tok.kind = KIND_ANCOUNT;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) begin
          an_left = tok.value[15:0];
          phase = PH_NS;
        end
      end
      PH_NS: begin
        tok.kind = KIND_NSCOUNT;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) begin
          ns_left = tok.value[15:0];
          phase = PH_AR;
        end
      end
      PH_AR: begin
        tok.kind = KIND_ARCOUNT;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) begin
          ar_left = tok.value[15:0];
          cur_sec = SEC_QUESTION;
          start_name();
        end
      end
      PH_NLEN: begin
        in_name = 1'b1;
        if (b[7:6] == 2'b11) begin
          tok.kind = KIND_POINTER;
          accum = {26'd0, b[5:0]};
          byte_cnt = 2'd1;
          tok.value = accum;
          phase = PH_NPTR;
        end else if (b == 8'h00) begin
          tok.kind = KIND_NAME_END;
          tok.done = 1'b1;
          phase = PH_TYPE;
        end else begin
          tok.kind = KIND_LABEL_LEN;
          tok.value = {24'd0, b};
          tok.done = 1'b1;
          lbl_left = b;
          grown = {1'b0, name_len} + {2'b00, b} + 10'd1;
          name_len = (grown > 10'd511) ? 9'd511 : grown[8:0];
          phase = PH_NCHAR;
        end
      end
      PH_NCHAR: begin
        in_name = 1'b1;
        tok.kind = KIND_LABEL_CHR;
        tok.value = {24'd0, b};
        tok.done = 1'b1;
        lbl_left = lbl_left - 8'd1;
        if (lbl_left == 0) phase = PH_NLEN;
      end
      PH_NPTR: begin
        in_name = 1'b1;
        tok.kind = KIND_POINTER;
        tok.value = {18'd0, accum[5:0], b};
        tok.done = 1'b1;
        accum = '0;
        byte_cnt = '0;
        phase = PH_TYPE;
      end
      PH_TYPE: begin
        tok.kind = KIND_TYPE;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) phase = PH_CLASS;
      end
      PH_CLASS: begin
        tok.kind = KIND_CLASS;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) begin
          if (cur_sec == SEC_QUESTION) next_record();
          else phase = PH_TTL;
        end
      end
      PH_TTL: begin
        tok.kind = KIND_TTL;
        tok.done = shift_field(4, b, tok.value);
        if (tok.done) phase = PH_RDLEN;
      end
      PH_RDLEN: begin
        tok.kind = KIND_RDLENGTH;
        tok.done = shift_field(2, b, tok.value);
        if (tok.done) begin
          rd_left = tok.value[15:0];
          if (rd_left == 0) next_record();
          else phase = PH_RDATA;
        end
      end
      PH_RDATA: begin
        tok.kind = KIND_RDATA;
        tok.value = {24'd0, b};
        tok.done = 1'b1;
        rd_left = rd_left - 16'd1;
        if (rd_left == 0) next_record();
      end
      default: begin
        tok.sec = SEC_TRAILING;
        cur_sec = SEC_TRAILING;
        phase = PH_TRAIL;
        tok.kind = KIND_EXTRA;
        tok.value = {24'd0, b};
        tok.done = 1'b1;
      end
    endcase
    tok.qr    = flags[15];
    tok.op    = flags[14:11];
    tok.aa    = flags[10];
    tok.tc    = flags[9];
    tok.rd    = flags[8];
    tok.ra    = flags[7];
    tok.rcode = flags[3:0];
    tok.ovf   = in_name && (name_len > 9'(NameMax));
    return tok;
  endfunction

  function automatic void check_field(input string nm, input logic [31:0] exp_v,
                                      input logic [31:0] got);
    if (got !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", nm, exp_v, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    dns_token_t exp_tok;
    bit         moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_tokens.push_back(parse_byte(msg_byte, msg_start));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_tokens.size() == 0) begin
          $error("token with no byte waiting: section %0d kind %0d", section, field_kind);
          err_count++;
        end else begin
          exp_tok = expected_tokens.pop_front();
          check_field("section", 32'(exp_tok.sec), 32'(section));
          check_field("field_kind", 32'(exp_tok.kind), 32'(field_kind));
          check_field("value", exp_tok.value, value);
          check_field("field_done", 32'(exp_tok.done), 32'(field_done));
          check_field("qr_flag", 32'(exp_tok.qr), 32'(qr_flag));
          check_field("op_code", 32'(exp_tok.op), 32'(op_code));
          check_field("aa_flag", 32'(exp_tok.aa), 32'(aa_flag));
          check_field("tc_flag", 32'(exp_tok.tc), 32'(tc_flag));
          check_field("rd_flag", 32'(exp_tok.rd), 32'(rd_flag));
          check_field("ra_flag", 32'(exp_tok.ra), 32'(ra_flag));
          check_field("resp_code", 32'(exp_tok.rcode), 32'(resp_code));
          check_field("name_overflow", 32'(exp_tok.ovf), 32'(name_overflow));
          tokens_checked++;
          if (exp_tok.ovf) overflow_seen++;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  always @(posedge clk) begin : output_stall
    int unsigned r;
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (rst || steady) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 92) begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(4, 29);
      end
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk);
    $display("dns_message_stream_parser_tb NOT OK");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    msg_byte  <= b;
    msg_start <= st;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned cut, input bit with_start);
    if (with_start) msgs_sent++;
    for (int unsigned i = 0; i < cut; i++) send_byte(wire_bytes[i], with_start && i == 0);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
  endtask

  function automatic void put8(input logic [7:0] b);
    wire_bytes.push_back(b);
  endfunction

  function automatic void put16(input logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  function automatic void put_label(input logic [7:0] len);
    put8(len);
    repeat (len) put8(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] pick_label_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(1, 10));
    if (r < 95) return 8'($urandom_range(11, 63));
    return 8'($urandom_range(64, 191));
  endfunction

  function automatic void put_name();
    repeat ($urandom_range(0, 3)) put_label(pick_label_len());
    if ($urandom_range(0, 3) == 0) begin
      put8({2'b11, 6'($urandom_range(0, 63))});
      put8(8'($urandom_range(0, 255)));
    end else begin
      put8(8'h00);
    end
  endfunction

  function automatic void put_record();
    int unsigned r;
    int unsigned rdlen;
    put_name();
    put16(16'($urandom_range(0, 65535)));
    put16(16'($urandom_range(0, 65535)));
    put32($urandom());
    r = $urandom_range(0, 99);
    if (r < 25) rdlen = 0;
    else if (r < 97) rdlen = $urandom_range(1, 6);
    else rdlen = $urandom_range(20, 40);
    put16(16'(rdlen));
    repeat (rdlen) put8(8'($urandom_range(0, 255)));
  endfunction

  function automatic int unsigned pick_count();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : 0;
  endfunction

  function automatic void build_random_message();
    int unsigned an;
    int unsigned ns;
    int unsigned ar;
    wire_bytes.delete();
    an = pick_count();
    ns = pick_count();
    ar = pick_count();
    put16(16'($urandom_range(0, 65535)));
    put16(16'($urandom_range(0, 65535)));
    put16(16'($urandom_range(0, 65535)));
    put16(16'(an));
    put16(16'(ns));
    put16(16'(ar));
    put_name();
    put16(16'($urandom_range(0, 65535)));
    put16(16'($urandom_range(0, 65535)));
    repeat (an + ns + ar) put_record();
    repeat ($urandom_range(0, 3)) put8(8'($urandom_range(0, 255)));
  endfunction

  // After reset the parse begins at the header id even without a start mark.
  task automatic test_parse_without_start();
    wire_bytes.delete();
    repeat (6) put16(16'h0000);
    put8(8'h00);
    put16(16'h0000);
    put16(16'h0000);
    put8(8'hFF);
    send_message(wire_bytes.size(), 1'b0);
  endtask

  task automatic test_restart_and_extremes();
    wire_bytes.delete();
    put16(16'hFFFF);
    put16(16'hFFFF);
    put16(16'hFFFF);
    put16(16'h0001);
    put16(16'h0000);
    put16(16'h0000);
    put8(8'hFF);
    put8(8'hFF);
    put16(16'hFFFF);
    put16(16'hFFFF);
    put8(8'h01);
    put8(8'h80);
    put8(8'h00);
    put16(16'h0001);
    put16(16'h0001);
    put32(32'hFFFF_FFFF);
    put16(16'h0000);
    put8(8'h00);
    send_message(3, 1'b1);
    send_message(wire_bytes.size(), 1'b1);
  endtask

  // The name reaches exactly the bound and then passes it.
  task automatic test_long_names();
    wire_bytes.delete();
    put16(16'($urandom_range(0, 65535)));
    put16(16'($urandom_range(0, 65535)));
    put16(16'h0001);
    put16(16'h0001);
    put16(16'h0000);
    put16(16'h0000);
    put_label(8'd127);
    put_label(8'd127);
    put_label(8'd1);
    put8(8'hC0);
    put8(8'h00);
    put16(16'h0001);
    put16(16'h0001);
    put_label(8'd3);
    put8(8'h00);
    put16(16'h0001);
    put16(16'h0001);
    put32(32'h0000_0000);
    put16(16'h0000);
    send_message(wire_bytes.size(), 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned first;
    int unsigned cut;
    first = bytes_sent;
    while (bytes_sent - first < 150) begin
      steady = ($urandom_range(0, 4) == 0);
      build_random_message();
      if ($urandom_range(0, 6) == 0) cut = $urandom_range(1, wire_bytes.size());
      else cut = wire_bytes.size();
      send_message(cut, 1'b1);
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 8));
    end
    steady = 1'b0;
  endtask

  task automatic test_noise();
    send_noise(20);
  endtask

  initial begin
    clear_parse();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_parse_without_start();
    test_restart_and_extremes();
    test_long_names();
    test_random_messages();
    test_noise();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Summary: %0d bytes in %0d messages, %0d tokens checked, %0d with a long name.",
             bytes_sent, msgs_sent, tokens_checked, overflow_seen);
    if (err_count == 0) begin
      $display("dns_message_stream_parser_tb OK");
    end else begin
      $display("dns_message_stream_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
